### src/rhc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared constants, types and helpers of the RGB / HSL color converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

    // fixed-point formats
    localparam int CH_BITS  = 16;
    localparam int HUE_FRAC = 6;
    localparam int DEN_W    = CH_BITS + 1;
    localparam int Q_W      = CH_BITS + 1;
    localparam int NUM_W    = 32;
    localparam int HUE_W    = 15;

    localparam logic [CH_BITS-1:0] CH_MAX     = '1;
    localparam logic [17:0]        TWO_ONE    = 18'd131072;
    localparam logic [11:0]        SEC        = 12'(60 << HUE_FRAC);
    localparam logic [HUE_W-1:0]   HUE_FULL   = 15'(6 * (60 << HUE_FRAC));
    localparam logic [HUE_W-1:0]   HUE_MAX    = 15'(6 * (60 << HUE_FRAC) - 1);
    localparam logic [15:0]        THR_RESET  = 16'd7;

    // conversion direction
    localparam logic MODE_RGB2HSL = 1'b0;
    localparam logic MODE_HSL2RGB = 1'b1;

    // 60-degree hue sectors
    localparam logic [2:0] SECT_0 = 3'd0;
    localparam logic [2:0] SECT_1 = 3'd1;
    localparam logic [2:0] SECT_2 = 3'd2;
    localparam logic [2:0] SECT_3 = 3'd3;
    localparam logic [2:0] SECT_4 = 3'd4;
    localparam logic [2:0] SECT_5 = 3'd5;

    // side data that travels with each word through the divider
    typedef struct packed {
        logic                mode;
        logic                gray;
        logic                neg;
        logic [CH_BITS-1:0]  l;
        logic [CH_BITS-1:0]  c;
        logic [2:0]          sector;
    } t_side;

    // round(comp + l - c/2), in doubled units, clamped to channel range
    function automatic logic [CH_BITS-1:0] add_m(input logic [CH_BITS-1:0] comp,
                                                 input logic [CH_BITS-1:0] l,
                                                 input logic [CH_BITS-1:0] c);
        logic [17:0] twice;
        logic [17:0] v;
        twice = {1'b0, comp, 1'b0} + {1'b0, l, 1'b0};
        if (twice >= 18'(c)) begin
            v = (twice - 18'(c) + 18'd1) >> 1;
        end else begin
            v = '0;
        end
        return (v > 18'(CH_MAX)) ? CH_MAX : v[CH_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

### src/rhc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_div
// Two pipelined restoring dividers, one quotient bit per stage, with
// a valid bit and side data carried alongside.
// ----------------------------------------------------------------------------
module rhc_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [rhc_pkg::NUM_W-1:0]     i_num_a,
    input  wire logic [rhc_pkg::DEN_W-1:0]     i_den_a,
    input  wire logic [rhc_pkg::NUM_W-1:0]     i_num_b,
    input  wire logic [rhc_pkg::DEN_W-1:0]     i_den_b,
    input  wire rhc_pkg::t_side                i_side,
    output logic                               o_valid,
    output logic [rhc_pkg::Q_W-1:0]            o_quot_a,
    output logic [rhc_pkg::Q_W-1:0]            o_quot_b,
    output rhc_pkg::t_side                     o_side
);

    localparam int QW = rhc_pkg::Q_W;
    localparam int DW = rhc_pkg::DEN_W;
    localparam int NW = rhc_pkg::NUM_W;

    logic          r_v     [QW];
    logic [DW-1:0] r_rem_a [QW];
    logic [DW-1:0] r_rem_b [QW];
    logic [QW-1:0] r_low_a [QW];
    logic [QW-1:0] r_low_b [QW];
    logic [QW-1:0] r_q_a   [QW];
    logic [QW-1:0] r_q_b   [QW];
    logic [DW-1:0] r_den_a [QW];
    logic [DW-1:0] r_den_b [QW];
    rhc_pkg::t_side r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          p_v;
        logic [DW-1:0] p_rem_a, p_rem_b, p_den_a, p_den_b;
        logic [QW-1:0] p_low_a, p_low_b, p_q_a, p_q_b;
        rhc_pkg::t_side p_side;
        logic [DW:0]   tr_a, tr_b;
        logic          ge_a, ge_b;

        // previous stage, or the operands for the first stage
        if (k == 0) begin : g_first
            assign p_v     = i_valid;
            assign p_rem_a = DW'(i_num_a[NW-1:QW]);
            assign p_rem_b = DW'(i_num_b[NW-1:QW]);
            assign p_low_a = i_num_a[QW-1:0];
            assign p_low_b = i_num_b[QW-1:0];
            assign p_q_a   = '0;
            assign p_q_b   = '0;
            assign p_den_a = i_den_a;
            assign p_den_b = i_den_b;
            assign p_side  = i_side;
        end else begin : g_next
            assign p_v     = r_v[k-1];
            assign p_rem_a = r_rem_a[k-1];
            assign p_rem_b = r_rem_b[k-1];
            assign p_low_a = r_low_a[k-1];
            assign p_low_b = r_low_b[k-1];
            assign p_q_a   = r_q_a[k-1];
            assign p_q_b   = r_q_b[k-1];
            assign p_den_a = r_den_a[k-1];
            assign p_den_b = r_den_b[k-1];
            assign p_side  = r_side[k-1];
        end

        // trial subtract
        assign tr_a = {p_rem_a, p_low_a[QW-1]};
        assign tr_b = {p_rem_b, p_low_b[QW-1]};
        assign ge_a = tr_a >= {1'b0, p_den_a};
        assign ge_b = tr_b >= {1'b0, p_den_b};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_a[k] <= ge_a ? DW'(tr_a - {1'b0, p_den_a}) : tr_a[DW-1:0];
                r_rem_b[k] <= ge_b ? DW'(tr_b - {1'b0, p_den_b}) : tr_b[DW-1:0];
                r_low_a[k] <= {p_low_a[QW-2:0], 1'b0};
                r_low_b[k] <= {p_low_b[QW-2:0], 1'b0};
                r_q_a[k]   <= {p_q_a[QW-2:0], ge_a};
                r_q_b[k]   <= {p_q_b[QW-2:0], ge_b};
                r_den_a[k] <= p_den_a;
                r_den_b[k] <= p_den_b;
                r_side[k]  <= p_side;
            end
        end
    end

    assign o_valid  = r_v[QW-1];
    assign o_quot_a = r_q_a[QW-1];
    assign o_quot_b = r_q_b[QW-1];
    assign o_side   = r_side[QW-1];

endmodule
`default_nettype wire

### src/rgb_hsl_color_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_hsl_color_converter
// Converts one pixel per word between RGB and HSL, direction chosen by
// i_mode (0: RGB to HSL, 1: HSL to RGB).
//
// Input channel: i_valid / o_stall, word taken when i_valid && !o_stall.
// Output channel: o_valid / i_stall, word taken when o_valid && !i_stall.
// Config channel: i_cfg_valid / o_cfg_ready / i_cfg_data writes the gray
// threshold; write only while the pipeline is empty.
// Pipeline: input register, three arithmetic stages, a 17-stage divider
// pipeline producing one quotient bit per stage, output register.
// Throughput: one word per cycle. The whole pipeline is frozen while the
// output holds a word and i_stall is high, so nothing is lost or repeated;
// o_stall is high exactly then.
// Reset: all valid bits clear, gray threshold returns to 7.
// ----------------------------------------------------------------------------
module rgb_hsl_color_converter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_mode,
    input  wire logic [15:0] i_first_value,
    input  wire logic [15:0] i_second_value,
    input  wire logic [15:0] i_third_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_first_result,
    output logic [15:0]      o_second_result,
    output logic [15:0]      o_third_result,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    localparam int CB = rhc_pkg::CH_BITS;
    localparam int HW = rhc_pkg::HUE_W;

    logic en;
    logic [15:0] r_thr;

    // global advance: frozen only when the output word is stalled
    assign en          = !o_valid || !i_stall;
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    // gray threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= rhc_pkg::THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    // stage 0: input register
    logic          r0_v, r0_mode;
    logic [CB-1:0] r0_a, r0_b, r0_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_mode <= i_mode;
            r0_a    <= i_first_value;
            r0_b    <= i_second_value;
            r0_c    <= i_third_value;
        end
    end

    // stage 1: extremes, spread, sectors, lightness terms
    logic [CB-1:0] mx, mn, d;
    logic [CB:0]   sum, den, two_l, t;
    logic          is_red, is_green, gray, neg;
    logic [18:0]   k;
    logic [31:0]   snum;
    logic [HW-1:0] h, pair_base;
    logic [2:0]    hsect;
    logic [12:0]   hp;
    logic [11:0]   f, w;
    rhc_pkg::t_side n1_side;

    always_comb begin
        mx = r0_a;
        mn = r0_a;
        if (r0_b > mx) mx = r0_b;
        if (r0_c > mx) mx = r0_c;
        if (r0_b < mn) mn = r0_b;
        if (r0_c < mn) mn = r0_c;
        d    = mx - mn;
        sum  = {1'b0, mx} + {1'b0, mn};
        den  = sum[CB] ? (CB+1)'(rhc_pkg::TWO_ONE - {1'b0, sum}) : sum;
        gray = (d == '0) || (d < r_thr);
        snum = {d, 16'h0000} + 32'(den >> 1);
        is_red   = (mx == r0_a);
        is_green = !is_red && (mx == r0_b);
        neg      = is_red && (r0_b < r0_c);
        if (is_red) begin
            k = neg ? 19'(r0_c - r0_b) : 19'(r0_b - r0_c);
        end else if (is_green) begin
            k = (19'(d) << 1) + 19'(r0_c) - 19'(r0_a);
        end else begin
            k = (19'(d) << 2) + 19'(r0_a) - 19'(r0_b);
        end

        // hsl side
        h     = (r0_a > 16'(rhc_pkg::HUE_MAX)) ? rhc_pkg::HUE_MAX : r0_a[HW-1:0];
        two_l = {r0_c, 1'b0};
        t     = two_l[CB] ? (CB+1)'(rhc_pkg::TWO_ONE - {1'b0, two_l}) : two_l;
        if (h >= HW'(5 * rhc_pkg::SEC))      hsect = rhc_pkg::SECT_5;
        else if (h >= HW'(4 * rhc_pkg::SEC)) hsect = rhc_pkg::SECT_4;
        else if (h >= HW'(3 * rhc_pkg::SEC)) hsect = rhc_pkg::SECT_3;
        else if (h >= HW'(2 * rhc_pkg::SEC)) hsect = rhc_pkg::SECT_2;
        else if (h >= HW'(rhc_pkg::SEC))     hsect = rhc_pkg::SECT_1;
        else                                 hsect = rhc_pkg::SECT_0;
        pair_base = HW'(hsect[2:1]) * HW'(2 * rhc_pkg::SEC);
        hp = 13'(h - pair_base);
        f  = (hp >= 13'(rhc_pkg::SEC)) ? 12'(hp - 13'(rhc_pkg::SEC))
                                       : 12'(13'(rhc_pkg::SEC) - hp);
        w  = rhc_pkg::SEC - f;

        n1_side.mode   = r0_mode;
        n1_side.gray   = gray;
        n1_side.neg    = neg;
        n1_side.l      = (r0_mode == rhc_pkg::MODE_HSL2RGB) ? r0_c : sum[CB:1];
        n1_side.c      = '0;
        n1_side.sector = hsect;
    end

    logic           r1_v;
    rhc_pkg::t_side r1_side;
    logic [18:0]    r1_k;
    logic [CB-1:0]  r1_d, r1_s;
    logic [31:0]    r1_snum;
    logic [CB:0]    r1_den, r1_t;
    logic [11:0]    r1_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_side <= n1_side;
            r1_k    <= k;
            r1_d    <= d;
            r1_s    <= r0_b;
            r1_snum <= snum;
            r1_den  <= den;
            r1_t    <= t;
            r1_w    <= w;
        end
    end

    // stage 2: hue numerator and chroma products
    logic [32:0] ts_prod;
    logic [31:0] n2_hnum;

    assign n2_hnum = 32'(31'(rhc_pkg::SEC) * 31'(r1_k)) + 32'(r1_d >> 1);
    assign ts_prod = 33'(r1_t) * 33'(r1_s) + 33'(1 << (CB - 1));

    logic           r2_v;
    rhc_pkg::t_side r2_side;
    logic [31:0]    r2_hnum, r2_snum;
    logic [CB:0]    r2_den;
    logic [CB-1:0]  r2_d, r2_c;
    logic [11:0]    r2_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_side <= r1_side;
            r2_hnum <= n2_hnum;
            r2_snum <= r1_snum;
            r2_den  <= r1_den;
            r2_d    <= r1_d;
            r2_c    <= ts_prod[2*CB-1:CB];
            r2_w    <= r1_w;
        end
    end

    // stage 3: secondary component numerator, divider operand select
    logic [27:0] xnum;
    rhc_pkg::t_side n3_side;

    assign xnum = 28'(r2_c) * 28'(r2_w) + 28'(rhc_pkg::SEC >> 1);

    always_comb begin
        n3_side   = r2_side;
        n3_side.c = r2_c;
    end

    logic           r3_v;
    rhc_pkg::t_side r3_side;
    logic [31:0]    r3_num_a, r3_num_b;
    logic [CB:0]    r3_den_a, r3_den_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_side <= n3_side;
            if (r2_side.mode == rhc_pkg::MODE_HSL2RGB) begin
                r3_num_a <= 32'(xnum);
                r3_den_a <= (CB+1)'(rhc_pkg::SEC);
            end else begin
                r3_num_a <= r2_snum;
                r3_den_a <= r2_den;
            end
            r3_num_b <= r2_hnum;
            r3_den_b <= {1'b0, r2_d};
        end
    end

    // divider pipeline
    logic           dv_v;
    logic [16:0]    q_a, q_b;
    rhc_pkg::t_side dv_side;

    rhc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r3_v),
        .i_num_a  (r3_num_a),
        .i_den_a  (r3_den_a),
        .i_num_b  (r3_num_b),
        .i_den_b  (r3_den_b),
        .i_side   (r3_side),
        .o_valid  (dv_v),
        .o_quot_a (q_a),
        .o_quot_b (q_b),
        .o_side   (dv_side)
    );

    // final: hue wrap, saturation clamp, channel assembly
    logic [HW-1:0] hq, hv;
    logic [CB-1:0] x, rp, gp, bp;
    logic [CB-1:0] n_first, n_second, n_third;

    always_comb begin
        hq = q_b[HW-1:0];
        hv = dv_side.neg ? (rhc_pkg::HUE_FULL - hq) : hq;
        if (hv >= rhc_pkg::HUE_FULL) hv = hv - rhc_pkg::HUE_FULL;
        x  = q_a[CB-1:0];
        case (dv_side.sector)
            rhc_pkg::SECT_0: begin rp = dv_side.c; gp = x;         bp = '0;        end
            rhc_pkg::SECT_1: begin rp = x;         gp = dv_side.c; bp = '0;        end
            rhc_pkg::SECT_2: begin rp = '0;        gp = dv_side.c; bp = x;         end
            rhc_pkg::SECT_3: begin rp = '0;        gp = x;         bp = dv_side.c; end
            rhc_pkg::SECT_4: begin rp = x;         gp = '0;        bp = dv_side.c; end
            default:         begin rp = dv_side.c; gp = '0;        bp = x;         end
        endcase
        if (dv_side.mode == rhc_pkg::MODE_HSL2RGB) begin
            n_first  = rhc_pkg::add_m(rp, dv_side.l, dv_side.c);
            n_second = rhc_pkg::add_m(gp, dv_side.l, dv_side.c);
            n_third  = rhc_pkg::add_m(bp, dv_side.l, dv_side.c);
        end else if (dv_side.gray) begin
            n_first  = '0;
            n_second = '0;
            n_third  = dv_side.l;
        end else begin
            n_first  = 16'(hv);
            n_second = q_a[CB] ? rhc_pkg::CH_MAX : q_a[CB-1:0];
            n_third  = dv_side.l;
        end
    end

    // output register
    logic [CB-1:0] r_first, r_second, r_third;
    logic          r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_third  <= n_third;
        end
    end

    assign o_valid         = r_ov;
    assign o_first_result  = r_first;
    assign o_second_result = r_second;
    assign o_third_result  = r_third;

endmodule
`default_nettype wire

### src/rhc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_checker
// Port-level checks of the converter's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module rhc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_stall,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic [15:0] o_first_result
);

    // a stalled output word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_first_result))
        else $error("output word dropped while stalled");

    // input is pushed back only when the output word is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output back-pressure");

    // input is never pushed back while output can drain
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) |-> !o_stall)
        else $error("input stalled with output free");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind rgb_hsl_color_converter rhc_checker u_rhc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_stall        (i_stall),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .o_first_result (o_first_result)
);
`default_nettype wire
